// ----- sv/tss_pkg.sv -----
// shared constants and types of the triangle scanline span block
// no dependencies; imported by every other file of the block
`default_nettype none
package tss_pkg;
  localparam int DEF_COORD_BITS = 13;
  localparam int LIMIT_BITS     = 12;
  localparam int COLOR_BITS     = 32;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [LIMIT_BITS-1:0] RESET_RIGHT_LIMIT  = 12'd800;
  localparam logic [LIMIT_BITS-1:0] RESET_BOTTOM_LIMIT = 12'd600;

  // register index taken from paddr[2]
  localparam logic REG_RIGHT_LIMIT  = 1'b0;
  localparam logic REG_BOTTOM_LIMIT = 1'b1;

  typedef struct packed {
    logic in_tri;
    logic on_screen;
  } row_flags_t;

  typedef struct packed {
    logic neg;
    logic den_zero;
  } lane_flags_t;
endpackage
`default_nettype wire

// ----- sv/tss_if.sv -----
// valid/ready channel interfaces for triangle spans in and spans out
// depends on tss_pkg
`default_nettype none
interface tss_in_if #(
  parameter int COORD_BITS = tss_pkg::DEF_COORD_BITS
);
  import tss_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;
  logic signed [COORD_BITS-1:0] row;
  logic [COLOR_BITS-1:0]        fill_color;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, row, fill_color, input ready);
  modport sink   (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, row, fill_color, output ready);
endinterface

interface tss_out_if #(
  parameter int COORD_BITS = tss_pkg::DEF_COORD_BITS
);
  import tss_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         row_inside;
  logic                         span_visible;
  logic signed [COORD_BITS-1:0] span_row;
  logic [LIMIT_BITS-1:0]        span_start;
  logic [LIMIT_BITS-1:0]        span_end;
  logic [COLOR_BITS-1:0]        span_color;

  modport source (output valid, row_inside, span_visible, span_row, span_start,
                  span_end, span_color, input ready);
  modport sink   (input valid, row_inside, span_visible, span_row, span_start,
                  span_end, span_color, output ready);
endinterface
`default_nettype wire

// ----- sv/tss_front.sv -----
// front end: vertex sort, edge setup, product and magnitude over four stages
// depends on tss_pkg
`default_nettype none
module tss_front #(
  parameter int COORD_BITS = tss_pkg::DEF_COORD_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [COORD_BITS-1:0]         ax_i,
  input  wire logic signed [COORD_BITS-1:0]         ay_i,
  input  wire logic signed [COORD_BITS-1:0]         bx_i,
  input  wire logic signed [COORD_BITS-1:0]         by_i,
  input  wire logic signed [COORD_BITS-1:0]         cx_i,
  input  wire logic signed [COORD_BITS-1:0]         cy_i,
  input  wire logic signed [COORD_BITS-1:0]         row_i,
  input  wire logic [tss_pkg::COLOR_BITS-1:0]       color_i,
  input  wire logic [tss_pkg::LIMIT_BITS-1:0]       bottom_limit_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [1:0][2*(COORD_BITS+1)-1:0]          num_mag_o,
  output logic [1:0][COORD_BITS-1:0]                den_o,
  output tss_pkg::lane_flags_t [1:0]                lane_o,
  output logic [1:0][COORD_BITS-1:0]                xs_o,
  output tss_pkg::row_flags_t                       flags_o,
  output logic [COORD_BITS-1:0]                     row_o,
  output logic [tss_pkg::COLOR_BITS-1:0]            color_o
);
  import tss_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW;
  localparam int EW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  logic [3:0] v_q;
  logic [4:0] rdy;
  assign rdy[4] = out_ready_i;
  for (genvar s = 0; s < 4; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage 1: three stable compare-swaps on y
  logic signed [CW-1:0] x1_d, y1_d, x2_d, y2_d, x3_d, y3_d;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, row1_q;
  logic [COLOR_BITS-1:0] color1_q;

  always_comb begin
    logic signed [CW-1:0] t;
    t = '0;
    x1_d = ax_i; y1_d = ay_i;
    x2_d = bx_i; y2_d = by_i;
    x3_d = cx_i; y3_d = cy_i;
    if (y1_d > y2_d) begin
      t = x1_d; x1_d = x2_d; x2_d = t;
      t = y1_d; y1_d = y2_d; y2_d = t;
    end
    if (y2_d > y3_d) begin
      t = x2_d; x2_d = x3_d; x3_d = t;
      t = y2_d; y2_d = y3_d; y3_d = t;
    end
    if (y1_d > y2_d) begin
      t = x1_d; x1_d = x2_d; x2_d = t;
      t = y1_d; y1_d = y2_d; y2_d = t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x1_q <= x1_d; y1_q <= y1_d;
      x2_q <= x2_d; y2_q <= y2_d;
      x3_q <= x3_d; y3_q <= y3_d;
      row1_q   <= row_i;
      color1_q <= color_i;
    end
  end

  // stage 2: edge choice and differences
  logic signed [DW-1:0] dx_d [2], dr_d [2], dy_d [2];
  logic signed [CW-1:0] xs_d [2];
  row_flags_t           flags_d;
  logic signed [DW-1:0] dx_q [2], dr_q [2];
  logic [CW-1:0]        den2_q [2];
  logic signed [CW-1:0] xs2_q [2];
  logic [1:0]           dz2_q;
  row_flags_t           flags2_q;
  logic [CW-1:0]        row2_q;
  logic [COLOR_BITS-1:0] color2_q;

  always_comb begin
    logic lower;
    logic signed [CW-1:0] ys_a, xe_a, ye_a;
    lower = row1_q < y2_q;
    xs_d[0] = lower ? x1_q : x2_q;
    ys_a    = lower ? y1_q : y2_q;
    xe_a    = lower ? x2_q : x3_q;
    ye_a    = lower ? y2_q : y3_q;
    dx_d[0] = sx(xe_a) - sx(xs_d[0]);
    dr_d[0] = sx(row1_q) - sx(ys_a);
    dy_d[0] = sx(ye_a) - sx(ys_a);
    xs_d[1] = x1_q;
    dx_d[1] = sx(x3_q) - sx(x1_q);
    dr_d[1] = sx(row1_q) - sx(y1_q);
    dy_d[1] = sx(y3_q) - sx(y1_q);
    flags_d.in_tri    = (row1_q >= y1_q) && (row1_q <= y3_q);
    flags_d.on_screen = !row1_q[CW-1] &&
                        (EW'(unsigned'(row1_q)) <= EW'(bottom_limit_i));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int l = 0; l < 2; l++) begin
        dx_q[l]   <= dx_d[l];
        dr_q[l]   <= dr_d[l];
        den2_q[l] <= dy_d[l][CW-1:0];
        dz2_q[l]  <= (dy_d[l] == '0);
        xs2_q[l]  <= xs_d[l];
      end
      flags2_q <= flags_d;
      row2_q   <= row1_q;
      color2_q <= color1_q;
    end
  end

  // stage 3: numerator product
  logic signed [NW-1:0] prod_q [2];
  logic [CW-1:0]        den3_q [2];
  logic signed [CW-1:0] xs3_q [2];
  logic [1:0]           dz3_q;
  row_flags_t           flags3_q;
  logic [CW-1:0]        row3_q;
  logic [COLOR_BITS-1:0] color3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int l = 0; l < 2; l++) begin
        prod_q[l] <= dx_q[l] * dr_q[l];
        den3_q[l] <= den2_q[l];
        xs3_q[l]  <= xs2_q[l];
      end
      dz3_q    <= dz2_q;
      flags3_q <= flags2_q;
      row3_q   <= row2_q;
      color3_q <= color2_q;
    end
  end

  // stage 4: sign and magnitude for the unsigned divider
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int l = 0; l < 2; l++) begin
        num_mag_o[l]       <= prod_q[l][NW-1] ? (~prod_q[l] + NW'(1)) : prod_q[l];
        lane_o[l].neg      <= prod_q[l][NW-1];
        lane_o[l].den_zero <= dz3_q[l];
        den_o[l]           <= den3_q[l];
        xs_o[l]            <= xs3_q[l];
      end
      flags_o <= flags3_q;
      row_o   <= row3_q;
      color_o <= color3_q;
    end
  end
endmodule
`default_nettype wire

// ----- sv/tss_div.sv -----
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on tss_pkg
`default_nettype none
module tss_div #(
  parameter int NUM_BITS  = 28,
  parameter int DEN_BITS  = 13,
  parameter int SIDE_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0][NUM_BITS-1:0]         num_i,
  input  wire logic [1:0][DEN_BITS-1:0]         den_i,
  input  wire logic [SIDE_BITS-1:0]             side_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0][NUM_BITS-1:0]              quo_o,
  output logic [SIDE_BITS-1:0]                  side_o
);
  import tss_pkg::*;

  localparam int AW = DEN_BITS + NUM_BITS;

  // partial remainder above, numerator bits shifting out and quotient bits in below
  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                             input logic [DEN_BITS-1:0] d);
    logic [AW:0]       sh;
    logic [DEN_BITS:0] trial;
    sh    = {acc, 1'b0};
    trial = sh[AW:NUM_BITS] - {1'b0, d};
    if (!trial[DEN_BITS]) begin
      return {trial[DEN_BITS-1:0], sh[NUM_BITS-1:1], 1'b1};
    end
    return sh[AW-1:0];
  endfunction

  logic [NUM_BITS-1:0]            v_q;
  logic [NUM_BITS:0]              rdy;
  logic [1:0][AW-1:0]             acc_q  [NUM_BITS];
  logic [1:0][DEN_BITS-1:0]       den_q  [NUM_BITS];
  logic [SIDE_BITS-1:0]           side_q [NUM_BITS];
  logic                           prv_v  [NUM_BITS];
  logic [1:0][AW-1:0]             prv_acc [NUM_BITS];
  logic [1:0][DEN_BITS-1:0]       prv_den [NUM_BITS];
  logic [SIDE_BITS-1:0]           prv_side [NUM_BITS];

  assign rdy[NUM_BITS] = out_ready_i;
  assign in_ready_o    = rdy[0];
  assign out_valid_o   = v_q[NUM_BITS-1];
  assign side_o        = side_q[NUM_BITS-1];
  assign quo_o[0]      = acc_q[NUM_BITS-1][0][NUM_BITS-1:0];
  assign quo_o[1]      = acc_q[NUM_BITS-1][1][NUM_BITS-1:0];

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    assign rdy[s] = !v_q[s] || rdy[s+1];
    if (s == 0) begin : g_first
      assign prv_v[s]      = in_valid_i;
      assign prv_acc[s][0] = {{DEN_BITS{1'b0}}, num_i[0]};
      assign prv_acc[s][1] = {{DEN_BITS{1'b0}}, num_i[1]};
      assign prv_den[s]    = den_i;
      assign prv_side[s]   = side_i;
    end else begin : g_next
      assign prv_v[s]    = v_q[s-1];
      assign prv_acc[s]  = acc_q[s-1];
      assign prv_den[s]  = den_q[s-1];
      assign prv_side[s] = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= prv_v[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        acc_q[s][0] <= div_step(prv_acc[s][0], prv_den[s][0]);
        acc_q[s][1] <= div_step(prv_acc[s][1], prv_den[s][1]);
        den_q[s]    <= prv_den[s];
        side_q[s]   <= prv_side[s];
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/tss_span.sv -----
// back end: edge x from quotient, ordering, clipping and output register
// depends on tss_pkg
`default_nettype none
module tss_span #(
  parameter int COORD_BITS = tss_pkg::DEF_COORD_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0][2*(COORD_BITS+1)-1:0]  quo_i,
  input  wire tss_pkg::lane_flags_t [1:0]        lane_i,
  input  wire logic [1:0][COORD_BITS-1:0]        xs_i,
  input  wire tss_pkg::row_flags_t               flags_i,
  input  wire logic [COORD_BITS-1:0]             row_i,
  input  wire logic [tss_pkg::COLOR_BITS-1:0]    color_i,
  input  wire logic [tss_pkg::LIMIT_BITS-1:0]    right_limit_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   row_inside_o,
  output logic                                   span_visible_o,
  output logic [COORD_BITS-1:0]                  span_row_o,
  output logic [tss_pkg::LIMIT_BITS-1:0]         span_start_o,
  output logic [tss_pkg::LIMIT_BITS-1:0]         span_end_o,
  output logic [tss_pkg::COLOR_BITS-1:0]         span_color_o
);
  import tss_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int NW = 2 * (CW + 1);
  localparam int XW = NW + 2;

  logic v_q;
  logic rdy;
  assign rdy         = !v_q || out_ready_i;
  assign in_ready_o  = rdy;
  assign out_valid_o = v_q;

  logic signed [XW-1:0] x   [2];
  logic signed [XW-1:0] lo, hi, lo_c, hi_c;
  logic                 vis;

  always_comb begin
    logic signed [XW-1:0] base, q;
    for (int l = 0; l < 2; l++) begin
      base = {{(XW-CW){xs_i[l][CW-1]}}, xs_i[l]};
      q    = {{(XW-NW){1'b0}}, quo_i[l]};
      if (lane_i[l].den_zero) begin
        x[l] = base;
      end else if (lane_i[l].neg) begin
        x[l] = base - q;
      end else begin
        x[l] = base + q;
      end
    end
    lo   = (x[0] < x[1]) ? x[0] : x[1];
    hi   = (x[0] < x[1]) ? x[1] : x[0];
    lo_c = lo[XW-1] ? '0 : lo;
    hi_c = (hi > $signed({{(XW-LIMIT_BITS){1'b0}}, right_limit_i}))
         ? $signed({{(XW-LIMIT_BITS){1'b0}}, right_limit_i}) : hi;
    vis  = flags_i.in_tri && flags_i.on_screen && (lo_c <= hi_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy) begin
      row_inside_o   <= flags_i.in_tri;
      span_visible_o <= vis;
      span_row_o     <= row_i;
      span_start_o   <= vis ? lo_c[LIMIT_BITS-1:0] : '0;
      span_end_o     <= vis ? hi_c[LIMIT_BITS-1:0] : '0;
      span_color_o   <= color_i;
    end
  end
endmodule
`default_nettype wire

// ----- sv/triangle_scanline_span.sv -----
// triangle scanline span: a valid/ready pipeline of front end, divider and back end
// throughput one transaction per cycle; each stage holds under back-pressure
// the divider is a restoring divider, one quotient bit per stage
// reset: asynchronous, active low; clears all valid bits, limits to 800 and 600
// depends on tss_pkg, tss_if, tss_front, tss_div, tss_span
`default_nettype none
module triangle_scanline_span #(
  parameter int COORD_BITS = tss_pkg::DEF_COORD_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  tss_in_if.sink                                     span_in_i,
  tss_out_if.source                                  span_out_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [tss_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [tss_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [tss_pkg::APB_DATA_BITS-1:0]          prdata,
  output logic                                       pready
);
  import tss_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int NW   = 2 * (CW + 1);
  // sideband through the divider: lane flags, edge start x, row flags, row, colour
  localparam int SBW  = 2 * $bits(lane_flags_t) + 2 * CW + $bits(row_flags_t)
                      + CW + COLOR_BITS;

  // configuration registers, written with the apb access phase
  logic [LIMIT_BITS-1:0] right_limit_q, bottom_limit_q;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_limit_q  <= RESET_RIGHT_LIMIT;
      bottom_limit_q <= RESET_BOTTOM_LIMIT;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_RIGHT_LIMIT:  right_limit_q  <= pwdata[LIMIT_BITS-1:0];
        REG_BOTTOM_LIMIT: bottom_limit_q <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RIGHT_LIMIT:  prdata = {{(APB_DATA_BITS-LIMIT_BITS){1'b0}}, right_limit_q};
      REG_BOTTOM_LIMIT: prdata = {{(APB_DATA_BITS-LIMIT_BITS){1'b0}}, bottom_limit_q};
      default:          prdata = '0;
    endcase
  end

  // front end: sort, edge setup, product, magnitude (four stages)
  logic                  f_valid, f_ready;
  logic [1:0][NW-1:0]    f_num;
  logic [1:0][CW-1:0]    f_den;
  lane_flags_t [1:0]     f_lane;
  logic [1:0][CW-1:0]    f_xs;
  row_flags_t            f_flags;
  logic [CW-1:0]         f_row;
  logic [COLOR_BITS-1:0] f_color;

  tss_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (span_in_i.valid),
    .in_ready_o     (span_in_i.ready),
    .ax_i           (span_in_i.vertex_a_x),
    .ay_i           (span_in_i.vertex_a_y),
    .bx_i           (span_in_i.vertex_b_x),
    .by_i           (span_in_i.vertex_b_y),
    .cx_i           (span_in_i.vertex_c_x),
    .cy_i           (span_in_i.vertex_c_y),
    .row_i          (span_in_i.row),
    .color_i        (span_in_i.fill_color),
    .bottom_limit_i (bottom_limit_q),
    .out_valid_o    (f_valid),
    .out_ready_i    (f_ready),
    .num_mag_o      (f_num),
    .den_o          (f_den),
    .lane_o         (f_lane),
    .xs_o           (f_xs),
    .flags_o        (f_flags),
    .row_o          (f_row),
    .color_o        (f_color)
  );

  // divider: both edges side by side, sideband rides along
  logic                  d_valid, d_ready;
  logic [1:0][NW-1:0]    d_quo;
  logic [SBW-1:0]        side_in, side_out;
  lane_flags_t [1:0]     d_lane;
  logic [1:0][CW-1:0]    d_xs;
  row_flags_t            d_flags;
  logic [CW-1:0]         d_row;
  logic [COLOR_BITS-1:0] d_color;

  assign side_in = {f_lane, f_xs, f_flags, f_row, f_color};
  assign {d_lane, d_xs, d_flags, d_row, d_color} = side_out;

  tss_div #(
    .NUM_BITS  (NW),
    .DEN_BITS  (CW),
    .SIDE_BITS (SBW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .num_i       (f_num),
    .den_i       (f_den),
    .side_i      (side_in),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .quo_o       (d_quo),
    .side_o      (side_out)
  );

  // back end: edge x, min/max, clip, output register
  tss_span #(.COORD_BITS(COORD_BITS)) u_span (
    .clk_i,
    .rst_ni,
    .in_valid_i     (d_valid),
    .in_ready_o     (d_ready),
    .quo_i          (d_quo),
    .lane_i         (d_lane),
    .xs_i           (d_xs),
    .flags_i        (d_flags),
    .row_i          (d_row),
    .color_i        (d_color),
    .right_limit_i  (right_limit_q),
    .out_valid_o    (span_out_o.valid),
    .out_ready_i    (span_out_o.ready),
    .row_inside_o   (span_out_o.row_inside),
    .span_visible_o (span_out_o.span_visible),
    .span_row_o     (span_out_o.span_row),
    .span_start_o   (span_out_o.span_start),
    .span_end_o     (span_out_o.span_end),
    .span_color_o   (span_out_o.span_color)
  );
endmodule
`default_nettype wire
